// ===== rtl/ede_pkg.sv =====
// ----------------------------------------------------------------------------
// ede_pkg: shared types and constants of the edit distance engine
// Word length limit, distance width, action codes and the beats that move
// between the top level and the cell chain.
// ----------------------------------------------------------------------------
package ede_pkg;

  // Longest word held; one cell per first-word symbol
  localparam int unsigned MAX_LEN = 64;
  // Width of a distance value inside the chain (holds MAX_LEN + 1)
  localparam int unsigned DW = $clog2(MAX_LEN + 2);
  // Width and ceiling of the reported distance field
  localparam int unsigned DIST_W   = 7;
  localparam int unsigned DIST_MAX = 127;

  typedef enum logic [1:0] {
    ACT_FIRST  = 2'd0,
    ACT_SECOND = 2'd1,
    ACT_FINISH = 2'd2
  } action_e;

  // Input beat
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] symbol;
  } in_t;

  // Result beat
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              too_long;
    logic              order_error;
  } out_t;

  // First-word append, broadcast to every cell
  typedef struct packed {
    logic       vld;
    logic [7:0] sym;
  } app_t;

  // Row update handed from a cell to its right neighbor
  typedef struct packed {
    logic          vld;
    logic [7:0]    sym;
    logic [DW-1:0] new_val;
    logic [DW-1:0] old_val;
  } upd_t;

  // Finish token collecting the distance along the chain
  typedef struct packed {
    logic          vld;
    logic [DW-1:0] val;
  } res_t;

endpackage

// ===== rtl/ede_cell.sv =====
// ----------------------------------------------------------------------------
// ede_cell: one column of the distance row
// Holds one first-word symbol and its distance entry, updates the entry when
// a second-word symbol passes by, and forwards the finish token.
// ----------------------------------------------------------------------------
module ede_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [ede_pkg::DW-1:0] idx_i,
  input  logic                   clr_i,
  input  ede_pkg::app_t          app_i,
  input  logic                   lfill_i,
  input  logic                   rfill_i,
  output logic                   fill_o,
  input  ede_pkg::upd_t          upd_i,
  output ede_pkg::upd_t          upd_o,
  input  ede_pkg::res_t          res_i,
  output ede_pkg::res_t          res_o
);
  import ede_pkg::*;

  logic          fill_q;
  logic [7:0]    sym_q;
  logic [DW-1:0] val_q, val_d;
  logic          upd_vld_q, res_vld_q;
  logic [7:0]    upd_sym_q;
  logic [DW-1:0] upd_new_q, upd_old_q, res_val_q;
  logic [DW-1:0] up_c, left_c, diag_c;
  logic          sel;

  // Compute the new entry: min of up + 1, left + 1, diagonal + mismatch
  always_comb begin
    up_c   = val_q + DW'(1);
    left_c = upd_i.new_val + DW'(1);
    diag_c = upd_i.old_val + ((upd_i.sym == sym_q) ? DW'(0) : DW'(1));
    val_d  = (up_c < left_c) ? up_c : left_c;
    if (diag_c < val_d) begin
      val_d = diag_c;
    end
  end

  // This cell holds the last first-word symbol
  assign sel = fill_q & ~rfill_i;

  // Store the next free first-word symbol
  always_ff @(posedge clk_i) begin
    if (app_i.vld && lfill_i && !fill_q) begin
      sym_q <= app_i.sym;
    end
  end

  // Advance the entry, the update wave and the finish token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= 1'b0;
      val_q     <= idx_i;
      upd_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else if (clr_i) begin
      fill_q    <= 1'b0;
      val_q     <= idx_i;
      upd_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (app_i.vld && lfill_i) begin
        fill_q <= 1'b1;
      end
      upd_vld_q <= upd_i.vld;
      if (upd_i.vld) begin
        val_q <= val_d;
      end
      res_vld_q <= res_i.vld;
    end
  end

  // Hold the handed-off payload
  always_ff @(posedge clk_i) begin
    if (upd_i.vld) begin
      upd_sym_q <= upd_i.sym;
      upd_new_q <= val_d;
      upd_old_q <= val_q;
    end
    if (res_i.vld) begin
      res_val_q <= sel ? val_q : res_i.val;
    end
  end

  assign fill_o = fill_q;
  assign upd_o  = '{vld: upd_vld_q, sym: upd_sym_q,
                    new_val: upd_new_q, old_val: upd_old_q};
  assign res_o  = '{vld: res_vld_q, val: res_val_q};

endmodule

// ===== rtl/edit_distance_engine_top.sv =====
// ----------------------------------------------------------------------------
// edit_distance_engine_top: Levenshtein distance over a chain of cells
// Issue a beat on in_i with start_i while busy_o is low. Action first appends
// a symbol to the first word, action second appends a symbol to the second
// word, action finish reports the distance and clears the block.
// Append beats may follow back to back: a second-word symbol enters cell one
// at once and its row update ripples one cell per cycle down the chain, so
// several symbols are in flight together.
// A finish beat sends a token down the same chain behind the last update; it
// picks up the entry of the cell that holds the last first-word symbol. The
// result appears on res_o with done_o high for one cycle, once the token has
// passed every cell; busy_o is raised by the finish beat and stays high until then.
// The result is presented for a single cycle and is not held; the receiver
// must take it then. Reset and finish both return every distance entry to its
// index and clear both words and the flags.
// Symbols past MAX_LEN set too_long; a first-word symbol after the second word
// began sets order_error. Neither produces a result.
// ----------------------------------------------------------------------------
module edit_distance_engine_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  ede_pkg::in_t   in_i,
  output logic           done_o,
  output ede_pkg::out_t  res_o
);
  import ede_pkg::*;

  logic          busy_q;
  logic          started_q, ovf_q, ord_q;
  logic [DW-1:0] row0_q;
  logic          acc, full1, full2, clr;
  logic          is_first, is_second, is_finish;
  app_t          app;
  upd_t          upd   [0:MAX_LEN];
  res_t          res   [0:MAX_LEN];
  logic          fill  [0:MAX_LEN+1];

  // Decode the input beat
  assign acc       = start_i & ~busy_q;
  assign is_first  = acc & (in_i.action == ACT_FIRST);
  assign is_second = acc & (in_i.action == ACT_SECOND);
  assign is_finish = acc & (in_i.action == ACT_FINISH);
  assign full1     = fill[MAX_LEN];
  assign full2     = (row0_q == DW'(MAX_LEN));

  // Feed the head of the chain
  assign fill[0]         = 1'b1;
  assign fill[MAX_LEN+1] = 1'b0;
  assign app.vld         = is_first & ~started_q & ~full1;
  assign app.sym         = in_i.symbol;
  assign upd[0].vld      = is_second & ~full2;
  assign upd[0].sym      = in_i.symbol;
  assign upd[0].new_val  = row0_q + DW'(1);
  assign upd[0].old_val  = row0_q;
  assign res[0].vld      = is_finish;
  assign res[0].val      = row0_q;

  // Token at the tail ends the pair
  assign clr = res[MAX_LEN].vld;

  for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
    ede_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (DW'(k)),
      .clr_i   (clr),
      .app_i   (app),
      .lfill_i (fill[k-1]),
      .rfill_i (fill[k+1]),
      .fill_o  (fill[k]),
      .upd_i   (upd[k-1]),
      .upd_o   (upd[k]),
      .res_i   (res[k-1]),
      .res_o   (res[k])
    );
  end

  // Track column zero, flags and the finish window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      started_q <= 1'b0;
      ovf_q     <= 1'b0;
      ord_q     <= 1'b0;
      row0_q    <= '0;
    end else if (clr) begin
      busy_q    <= 1'b0;
      started_q <= 1'b0;
      ovf_q     <= 1'b0;
      ord_q     <= 1'b0;
      row0_q    <= '0;
    end else begin
      if (is_finish) begin
        busy_q <= 1'b1;
      end
      if (is_first) begin
        if (started_q) begin
          ord_q <= 1'b1;
        end else if (full1) begin
          ovf_q <= 1'b1;
        end
      end
      if (is_second) begin
        started_q <= 1'b1;
        if (full2) begin
          ovf_q <= 1'b1;
        end else begin
          row0_q <= row0_q + DW'(1);
        end
      end
    end
  end

  // Drive the result beat
  always_comb begin
    if (int'(res[MAX_LEN].val) > DIST_MAX) begin
      res_o.distance = DIST_W'(DIST_MAX);
    end else begin
      res_o.distance = DIST_W'(res[MAX_LEN].val);
    end
    res_o.too_long    = ovf_q;
    res_o.order_error = ord_q;
  end

  assign done_o = res[MAX_LEN].vld;
  assign busy_o = busy_q;

  // A result only closes a finish window
  a_done_in_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_q)
    else $error("result outside finish window");

  // A finish beat opens the window by raising busy_o, a registered flag
  a_finish_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_finish |=> busy_o)
    else $error("finish beat did not raise busy");

  // No second-word update may enter past the word limit
  a_row0_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd[0].vld |-> (row0_q < DW'(MAX_LEN)))
    else $error("second word update beyond limit");

  // Reported distance never exceeds the longest word
  a_dist_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (int'(res[MAX_LEN].val) <= int'(MAX_LEN)))
    else $error("distance beyond word limit");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the edit distance engine
// Walk a short table of hand-picked beats, then stream random word pairs.
// Every accepted beat runs through a local Levenshtein tracker. Every finish
// queues its distance and flags, and each done_o strobe is matched in order
// against the oldest queued entry.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ede_pkg::*;

  // Action code with no meaning; the block must ignore it
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_LIMIT = 8 * MAX_LEN;

  typedef struct packed {
    in_t  beat;
    logic has_want;
    out_t want;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  in_t  in_i;
  logic done_o;
  out_t res_o;

  edit_distance_engine_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .in_i   (in_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // Directed beats; typed results only where they are obvious
  plan_row_t plan [0:23] = '{
    '{'{ACT_FINISH, 8'h00}, 1'b1, '{7'd0, 1'b0, 1'b0}},
    '{'{ACT_FIRST,  8'h00}, 1'b0, '0},
    '{'{ACT_FIRST,  8'hFF}, 1'b0, '0},
    '{'{ACT_SECOND, 8'hFF}, 1'b0, '0},
    '{'{ACT_SECOND, 8'h00}, 1'b0, '0},
    '{'{ACT_FINISH, 8'h5A}, 1'b0, '0},
    '{'{ACT_FIRST,  8'hAA}, 1'b0, '0},
    '{'{ACT_FIRST,  8'h55}, 1'b0, '0},
    '{'{ACT_FINISH, 8'hFF}, 1'b1, '{7'd2, 1'b0, 1'b0}},
    '{'{ACT_SECOND, 8'h01}, 1'b0, '0},
    '{'{ACT_SECOND, 8'h02}, 1'b0, '0},
    '{'{ACT_SECOND, 8'h03}, 1'b0, '0},
    '{'{ACT_FINISH, 8'hA5}, 1'b1, '{7'd3, 1'b0, 1'b0}},
    '{'{ACT_SECOND, 8'h41}, 1'b0, '0},
    '{'{ACT_FIRST,  8'h41}, 1'b0, '0},
    '{'{ACT_FINISH, 8'h00}, 1'b1, '{7'd1, 1'b0, 1'b1}},
    '{'{ACT_FIRST,  8'h10}, 1'b0, '0},
    '{'{ACT_UNUSED, 8'h10}, 1'b0, '0},
    '{'{ACT_SECOND, 8'h10}, 1'b0, '0},
    '{'{ACT_FINISH, 8'h77}, 1'b1, '{7'd0, 1'b0, 1'b0}},
    '{'{ACT_FIRST,  8'h80}, 1'b0, '0},
    '{'{ACT_SECOND, 8'h7F}, 1'b0, '0},
    '{'{ACT_SECOND, 8'h80}, 1'b0, '0},
    '{'{ACT_FINISH, 8'hC3}, 1'b0, '0}
  };

  // Local copy of the engine state
  logic [7:0]  word_a [MAX_LEN];
  int unsigned dist_row [MAX_LEN+1];
  int unsigned len_a;
  int unsigned len_b;
  bit          second_begun;
  bit          overflow_flag;
  bit          order_flag;

  out_t        pending_distances [$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned beats_sent;

  // Clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Return the tracked state to its cleared form
  function automatic void clear_pair();
    for (int i = 0; i <= MAX_LEN; i++) dist_row[i] = i;
    len_a         = 0;
    len_b         = 0;
    second_begun  = 1'b0;
    overflow_flag = 1'b0;
    order_flag    = 1'b0;
  endfunction

  // Apply one beat to the tracked state; return 1 when it yields a result
  function automatic bit advance_distance(input in_t b, output out_t res);
    int unsigned diag;
    int unsigned up;
    int unsigned sub;
    int unsigned best;
    int unsigned d;
    res = '0;
    case (b.action)
      ACT_FIRST: begin
        if (second_begun) order_flag = 1'b1;
        else if (len_a >= MAX_LEN) overflow_flag = 1'b1;
        else begin
          word_a[len_a] = b.symbol;
          len_a++;
        end
      end
      ACT_SECOND: begin
        second_begun = 1'b1;
        if (len_b >= MAX_LEN) overflow_flag = 1'b1;
        else begin
          // Update one row of the distance table against the first word
          diag        = dist_row[0];
          dist_row[0] = diag + 1;
          for (int i = 1; i <= len_a; i++) begin
            up   = dist_row[i];
            sub  = diag + ((word_a[i-1] == b.symbol) ? 0 : 1);
            best = (up + 1 < dist_row[i-1] + 1) ? up + 1 : dist_row[i-1] + 1;
            dist_row[i] = (sub < best) ? sub : best;
            diag = up;
          end
          len_b++;
        end
      end
      ACT_FINISH: begin
        d = dist_row[len_a];
        if (d > DIST_MAX) d = DIST_MAX;
        res.distance    = d[DIST_W-1:0];
        res.too_long    = overflow_flag;
        res.order_error = order_flag;
        clear_pair();
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Offer one beat after a random idle stretch; track it once accepted
  task automatic send_beat(input in_t b, input logic has_want, input out_t want);
    int unsigned gap;
    out_t        res;
    gap = 0;
    while (gap < 24 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= b;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    if (advance_distance(b, res))
      pending_distances.insert(pending_distances.size(), has_want ? want : res);
    if (b.action != ACT_UNUSED) beats_sent++;
  endtask

  // Hold off the sender until every queued result has come back
  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_distances.size() != 0);
  endtask

  // Mostly short words, a few empty, a few close to or past the length limit
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return $urandom_range(MAX_LEN - 4, MAX_LEN + 4);
    if (r < 11) return 0;
    return $urandom_range(1, 9);
  endfunction

  function automatic logic [7:0] pick_symbol(input logic [7:0] base, input int unsigned spread);
    if (spread == 0) return 8'($urandom_range(0, 255));
    return base + 8'($urandom_range(0, spread));
  endfunction

  // Stream word pairs until the beat budget for this phase is used up
  task automatic run_random(input int unsigned budget);
    int unsigned stop_at;
    int unsigned n_a;
    int unsigned n_b;
    int unsigned spread;
    logic [7:0]  base;
    in_t         b;
    stop_at = beats_sent + budget;
    while (beats_sent < stop_at) begin
      n_a    = pick_len();
      n_b    = pick_len();
      spread = $urandom_range(0, 3);
      base   = 8'($urandom_range(0, 255));
      for (int i = 0; i < n_a; i++) begin
        b = '{ACT_FIRST, pick_symbol(base, spread)};
        send_beat(b, 1'b0, '0);
      end
      for (int i = 0; i < n_b; i++) begin
        b = '{ACT_SECOND, pick_symbol(base, spread)};
        send_beat(b, 1'b0, '0);
        // Drop in a late first-word symbol or a raw beat now and then
        if ($urandom_range(0, 99) < 6) begin
          b = '{ACT_FIRST, pick_symbol(base, spread)};
          send_beat(b, 1'b0, '0);
        end
        if ($urandom_range(0, 99) < 3) begin
          b = '{2'($urandom_range(0, 3)), 8'($urandom_range(0, 255))};
          send_beat(b, 1'b0, '0);
        end
      end
      b = '{ACT_FINISH, 8'($urandom_range(0, 255))};
      send_beat(b, 1'b0, '0);
    end
  endtask

  // Match each result strobe against the oldest queued result
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_distances.size() == 0) begin
        $display("%0t: unexpected result dist=%0d too_long=%0b order_error=%0b",
                 $time, res_o.distance, res_o.too_long, res_o.order_error);
        error_count++;
      end else begin
        want = pending_distances.pop_front();
        if (res_o.distance !== want.distance || res_o.too_long !== want.too_long ||
            res_o.order_error !== want.order_error) begin
          $display("%0t: mismatch expected dist=%0d too_long=%0b order_error=%0b",
                   $time, want.distance, want.too_long, want.order_error,
                   ", got dist=%0d too_long=%0b order_error=%0b",
                   res_o.distance, res_o.too_long, res_o.order_error);
          error_count++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned waited;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    in_i          = '0;
    error_count   = 0;
    cycle_count   = 0;
    beats_sent    = 0;
    send_idle_pct = 0;
    clear_pair();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int k = 0; k < $size(plan); k++)
      send_beat(plan[k].beat, plan[k].has_want, plan[k].want);

    // Random phases: light sender idling, heavy idling, none
    send_idle_pct = 36;
    run_random(400);
    drain_results();
    send_idle_pct = 82;
    run_random(400);
    drain_results();
    send_idle_pct = 0;
    run_random(400);
    start_i <= 1'b0;

    // Wait out the last results, then let the chain settle
    waited = 0;
    while (pending_distances.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (MAX_LEN + 16) @(posedge clk_i);
    if (pending_distances.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_distances.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ede_pkg.sv
rtl/ede_cell.sv
rtl/edit_distance_engine_top.sv
sim/tb_top.sv
